// ===== rtl/text_plane_glyph_renderer_unit_assert.svh =====
// Assertion macros shared by the text plane renderer RTL.
`ifndef TEXT_PLANE_GLYPH_RENDERER_UNIT_ASSERT_SVH
`define TEXT_PLANE_GLYPH_RENDERER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPGR_ASSERT_HOLDS(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tpgr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPGR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tpgr: next-cycle check failed");

`endif

// ===== rtl/tpgr_pkg.sv =====
package tpgr_pkg;

    // default geometry of the text plane
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // font store: 256 glyphs x 16 lines
    localparam int FONT_AW    = 12;
    localparam int GLYPH_ROWS = 16;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 10;

    localparam logic [9:0] SCREEN_HEIGHT_RST = 10'd400;
    localparam logic [3:0] LAST_LINE         = 4'd15;
    localparam logic [7:0] FULL_MASK         = 8'hff;

    // attribute bit positions
    localparam int ATTR_DISPLAY_BIT = 0;
    localparam int ATTR_REVERSE_BIT = 2;
    localparam int ATTR_UNDER_BIT   = 3;
    localparam int ATTR_COLOR_LSB   = 5;
    localparam logic [7:0] ATTR_DISPLAY_ONLY = 8'h01;

    typedef enum logic [1:0] {
        KIND_PUT_CHAR   = 2'd0,
        KIND_FONT_WRITE = 2'd1,
        KIND_CLEAR      = 2'd2,
        KIND_RENDER     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_PALETTE_BASE  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_FONT_READY    = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT2,
        ST_CELL,
        ST_FONT
    } state_t;

    // input item, last field in the lowest bits
    typedef struct packed {
        logic        pad;
        logic [3:0]  scan_line;
        logic [6:0]  text_col;
        logic [4:0]  text_row;
        logic [15:0] font_bits;
        logic [3:0]  font_line;
        logic [7:0]  attribute;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } in_data_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [5:0] pad;
        logic       bg_opaque;
        logic [7:0] bg_color;
        logic [7:0] fg_color;
        logic [7:0] pixel_bits;
        logic       drawn;
    } out_data_t;

    // one entry of the cell store
    typedef struct packed {
        logic       half;
        logic [7:0] glyph;
        logic [7:0] attr;
    } cell_word_t;

    // what the shading stage needs besides the font word
    typedef struct packed {
        logic       ok;
        logic       half;
        logic [7:0] attr;
        logic [3:0] line;
    } shade_in_t;

endpackage

// ===== rtl/tpgr_shade.sv =====
module tpgr_shade (
    input  tpgr_pkg::shade_in_t sh_in,
    input  logic [7:0]          palette_base,
    input  logic [15:0]         font_word,
    output tpgr_pkg::out_data_t result
);
    import tpgr_pkg::*;

    logic [7:0] color;
    logic [7:0] bits;
    logic       reverse;
    logic       drawn;

    always_comb begin
        color   = palette_base + {5'd0, sh_in.attr[ATTR_COLOR_LSB +: 3]};
        reverse = sh_in.attr[ATTR_REVERSE_BIT];
        // right half of a wide glyph sits in the low byte
        bits    = sh_in.half ? font_word[7:0] : font_word[15:8];
        if (sh_in.attr[ATTR_UNDER_BIT] && (sh_in.line == LAST_LINE)) begin
            bits = FULL_MASK;
        end
        drawn = sh_in.ok && ((bits != 8'd0) || reverse);

        result = '0;
        if (drawn) begin
            result.drawn      = 1'b1;
            result.pixel_bits = bits;
            result.fg_color   = reverse ? palette_base : color;
            result.bg_color   = reverse ? color : 8'd0;
            result.bg_opaque  = reverse;
        end
    end

endmodule

// ===== rtl/text_plane_glyph_renderer_unit.sv =====
// Text plane glyph renderer: character cells, 16x16 font, 8-pixel slice render.
// Render: the result item passes the cell read, the font read and the output register, and
// no input item is taken meanwhile; a result held by m_tready holds the next input item.
// Put char writes the left and then the right half cell (one cell store write port).
// Clear and reset zero all ROWS*COLUMNS cells of the cell store (2000 by default);
// no input item is taken during the sweep. aresetn is synchronous, active low.
`include "text_plane_glyph_renderer_unit_assert.svh"

module text_plane_glyph_renderer_unit #(
    parameter int COLUMNS = tpgr_pkg::COLUMNS_DEF,
    parameter int ROWS    = tpgr_pkg::ROWS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [tpgr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpgr_pkg::CFG_W-1:0]          cfg_wr_data,

    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cell_index, char_code, attribute, font_line, font_bits,
    // text_row, text_col, scan_line, one zero pad bit
    input  tpgr_pkg::in_data_t                  s_tdata,
    // kind
    input  tpgr_pkg::kind_t                     s_tuser,

    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // drawn, pixel_bits, fg_color, bg_color, bg_opaque, six zero pad bits
    output tpgr_pkg::out_data_t                 m_tdata
);
    import tpgr_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [7:0] palette_base_reg;
    logic [9:0] screen_height_reg;
    logic       font_ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_base_reg  <= '0;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            font_ready_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_PALETTE_BASE:  palette_base_reg  <= cfg_wr_data[7:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wr_data[9:0];
                CFG_FONT_READY:    font_ready_reg    <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stores: cell store (glyph, half, attribute) and font store
    // ------------------------------------------------------------------
    cell_word_t  cell_mem [CELL_COUNT];
    logic [15:0] font_mem [2**FONT_AW];

    logic               cell_we;
    logic [CELL_AW-1:0] cell_wa;
    cell_word_t         cell_wd;
    logic               cell_re;
    logic [CELL_AW-1:0] cell_ra;
    cell_word_t         cell_q;

    logic               font_we;
    logic [FONT_AW-1:0] font_wa;
    logic [15:0]        font_wd;
    logic               font_re;
    logic [FONT_AW-1:0] font_ra;
    logic [15:0]        font_q;

    always_ff @(posedge aclk) begin
        if (cell_we) begin
            cell_mem[cell_wa] <= cell_wd;
        end
        if (cell_re) begin
            cell_q <= cell_mem[cell_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (font_we) begin
            font_mem[font_wa] <= font_wd;
        end
        if (font_re) begin
            font_q <= font_mem[font_ra];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [CELL_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [11:0]        put_idx_reg, put_idx_next;
    cell_word_t         put_word_reg, put_word_next;
    logic               rnd_ok_reg, rnd_ok_next;
    logic [3:0]         line_reg, line_next;
    shade_in_t          shade_reg, shade_next;

    logic               out_free;
    logic               out_load;
    out_data_t          shade_out;

    logic [11:0]        put_idx;
    logic [31:0]        rnd_idx;
    logic               rnd_in_range;
    logic [7:0]         put_attr;

    always_comb begin
        // cell number of the render target and the range checks on it
        rnd_idx      = 32'(s_tdata.text_row) * 32'(COLUMNS) + 32'(s_tdata.text_col);
        rnd_in_range = (32'(s_tdata.text_row) < 32'(ROWS))
                    && (32'(s_tdata.text_col) < 32'(COLUMNS));
        put_idx      = {1'b0, s_tdata.cell_index};
        // attribute 0 turns into display only
        put_attr     = (s_tdata.attribute != 8'd0) ? s_tdata.attribute : ATTR_DISPLAY_ONLY;
    end

    assign out_free = !m_tvalid || m_tready;

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        put_idx_next  = put_idx_reg;
        put_word_next = put_word_reg;
        rnd_ok_next   = rnd_ok_reg;
        line_next     = line_reg;
        shade_next    = shade_reg;

        s_tready = 1'b0;
        out_load = 1'b0;
        cell_we  = 1'b0;
        cell_wa  = clr_cnt_reg;
        cell_wd  = '0;
        cell_re  = 1'b0;
        cell_ra  = '0;
        font_we  = 1'b0;
        font_wa  = {s_tdata.char_code, s_tdata.font_line};
        font_wd  = s_tdata.font_bits;
        font_re  = 1'b0;
        font_ra  = {cell_q.glyph, line_reg};

        case (state_reg)
            ST_CLEAR: begin
                // zero one cell a cycle
                cell_we = 1'b1;
                if (clr_cnt_reg == CELL_AW'(CELL_COUNT - 1)) begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + CELL_AW'(1);
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (s_tuser)
                        KIND_PUT_CHAR: begin
                            // left half now, right half next cycle
                            cell_we            = (32'(put_idx) < 32'(CELL_COUNT));
                            cell_wa            = put_idx[CELL_AW-1:0];
                            cell_wd.half       = 1'b0;
                            cell_wd.glyph      = s_tdata.char_code;
                            cell_wd.attr       = put_attr;
                            put_idx_next       = put_idx + 12'd1;
                            put_word_next.half = 1'b1;
                            put_word_next.glyph = s_tdata.char_code;
                            put_word_next.attr = put_attr;
                            state_next         = ST_PUT2;
                        end
                        KIND_FONT_WRITE: begin
                            font_we = 1'b1;
                        end
                        KIND_CLEAR: begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        KIND_RENDER: begin
                            // out-of-range cells read entry 0 and are dropped later
                            cell_re     = 1'b1;
                            cell_ra     = rnd_in_range ? rnd_idx[CELL_AW-1:0] : '0;
                            rnd_ok_next = font_ready_reg && rnd_in_range
                                && ({1'b0, s_tdata.text_row, s_tdata.scan_line}
                                    < screen_height_reg);
                            line_next   = s_tdata.scan_line;
                            state_next  = ST_CELL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PUT2: begin
                cell_we    = (32'(put_idx_reg) < 32'(CELL_COUNT));
                cell_wa    = put_idx_reg[CELL_AW-1:0];
                cell_wd    = put_word_reg;
                state_next = ST_IDLE;
            end
            ST_CELL: begin
                // cell entry is here: fetch its glyph line
                font_re         = 1'b1;
                shade_next.ok   = rnd_ok_reg && cell_q.attr[ATTR_DISPLAY_BIT];
                shade_next.half = cell_q.half;
                shade_next.attr = cell_q.attr;
                shade_next.line = line_reg;
                state_next      = ST_FONT;
            end
            ST_FONT: begin
                // hold until the output register is free
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        put_idx_reg  <= put_idx_next;
        put_word_reg <= put_word_next;
        rnd_ok_reg   <= rnd_ok_next;
        line_reg     <= line_next;
        shade_reg    <= shade_next;
    end

    // ------------------------------------------------------------------
    // shading and output register
    // ------------------------------------------------------------------
    tpgr_shade u_shade (
        .sh_in        (shade_reg),
        .palette_base (palette_base_reg),
        .font_word    (font_q),
        .result       (shade_out)
    );

    logic      m_valid_reg, m_valid_next;
    out_data_t m_data_reg, m_data_next;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = shade_out;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `TPGR_ASSERT_HOLDS(a_undrawn_is_zero, aclk, aresetn, m_valid_reg && !m_data_reg.drawn, m_data_reg == '0)
    `TPGR_ASSERT_HOLDS(a_drawn_has_pixels, aclk, aresetn, m_valid_reg && m_data_reg.drawn && !m_data_reg.bg_opaque, m_data_reg.pixel_bits != 8'd0)
    `TPGR_ASSERT_HOLDS(a_sweep_in_range, aclk, aresetn, state_reg == ST_CLEAR, 32'(clr_cnt_reg) < 32'(CELL_COUNT))
    `TPGR_ASSERT_NEXT(a_font_waits_for_output, aclk, aresetn, (state_reg == ST_FONT) && m_valid_reg && !m_tready, state_reg == ST_FONT)

endmodule
